[hdl/tptgt_pkg.sv]
`default_nettype none
package tptgt_pkg;

    localparam int POS_WIDTH  = 32;
    localparam int QUAT_WIDTH = 16;
    localparam int QFRAC      = QUAT_WIDTH - 2;
    localparam int CFG_WIDTH  = 32;
    localparam int CFG_IDX_W  = 4;

    localparam logic [CFG_IDX_W-1:0] REG_POSITION_SCALE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X       = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y       = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z       = 4'd3;

    localparam logic [15:0] SCALE_RESET = 16'd12800;

    typedef struct packed {
        logic signed [POS_WIDTH-1:0]  pos_x;
        logic signed [POS_WIDTH-1:0]  pos_y;
        logic signed [POS_WIDTH-1:0]  pos_z;
        logic signed [QUAT_WIDTH-1:0] quat_w;
        logic signed [QUAT_WIDTH-1:0] quat_x;
        logic signed [QUAT_WIDTH-1:0] quat_y;
        logic signed [QUAT_WIDTH-1:0] quat_z;
    } pose_in_t;

    typedef struct packed {
        logic signed [POS_WIDTH-1:0]  game_x;
        logic signed [POS_WIDTH-1:0]  game_y;
        logic signed [POS_WIDTH-1:0]  game_z;
        logic signed [QUAT_WIDTH-1:0] m00;
        logic signed [QUAT_WIDTH-1:0] m01;
        logic signed [QUAT_WIDTH-1:0] m02;
        logic signed [QUAT_WIDTH-1:0] m10;
        logic signed [QUAT_WIDTH-1:0] m11;
        logic signed [QUAT_WIDTH-1:0] m12;
        logic signed [QUAT_WIDTH-1:0] m20;
        logic signed [QUAT_WIDTH-1:0] m21;
        logic signed [QUAT_WIDTH-1:0] m22;
    } pose_out_t;

endpackage
`default_nettype wire

[hdl/tracked_pose_to_game_transform.sv]
`default_nettype none
// channel | signals                          | beat
// pose in | in_valid, in_ready, in_data      | position and quaternion
// pose out| out_valid, out_ready, out_data   | game position and 3x3 matrix
// config  | cfg_we, cfg_index, cfg_data      | one register write per cycle
//
// one beat per cycle while out_ready is high; three arithmetic stages,
// a 16-stage restoring divider (one quotient bit per stage, nine lanes) and
// the output register
// reset (rst_n, async) empties the pipe and loads scale 50.0 and zero offsets
// each stage holds while the next is full and stalled; empty stages fill in
module tracked_pose_to_game_transform
(
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   in_valid,
    output logic                                  in_ready,
    input  wire tptgt_pkg::pose_in_t              in_data,
    output logic                                  out_valid,
    input  wire                                   out_ready,
    output tptgt_pkg::pose_out_t                  out_data,
    input  wire                                   cfg_we,
    input  wire [tptgt_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire [tptgt_pkg::CFG_WIDTH-1:0]        cfg_data
);
    localparam int PW    = tptgt_pkg::POS_WIDTH;
    localparam int QW    = tptgt_pkg::QUAT_WIDTH;
    localparam int QF    = tptgt_pkg::QFRAC;
    localparam int CW    = QW + 1;          // rotated component
    localparam int MW    = 2 * CW;          // component product
    localparam int NW    = MW + 4;          // norm and numerators, signed
    localparam int DW    = MW + 2;          // divider remainder / divisor
    localparam int QBW   = QF + 2;          // raw quotient bits
    localparam int PMW   = PW + 1;          // remapped position
    localparam int PRW   = PMW + 17;        // position times scale
    localparam int PSW   = PRW - 8 + 1;     // shifted plus offset
    localparam int NSTEP = QF + 1;
    localparam int NSTG  = 5 + NSTEP;
    localparam int DIV0  = 3;
    localparam int OSTG  = NSTG - 1;

    typedef struct packed {
        logic [3:0][CW-1:0]  comp;   // a b c d
        logic [2:0][PMW-1:0] pm;
    } s1_t;

    typedef struct packed {
        logic [9:0][MW-1:0]  prod;   // aa bb cc dd bc ad bd ac cd ab
        logic [2:0][PRW-1:0] pp;
    } s2_t;

    typedef struct packed {
        logic [NW-1:0]       n;
        logic [8:0][NW-1:0]  num;
        logic [2:0][PSW-1:0] psum;
    } s3_t;

    typedef struct packed {
        logic [8:0][DW-1:0]  r;
        logic [8:0][QBW-1:0] q;
        logic [8:0]          neg;
        logic [DW-1:0]       den;
        logic                zero;
        logic [2:0][PW-1:0]  game;
    } div_t;

    // configuration
    logic        [15:0] scale_reg;
    logic signed [31:0] off_x_reg, off_y_reg, off_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= tptgt_pkg::SCALE_RESET;
            off_x_reg <= '0;
            off_y_reg <= '0;
            off_z_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tptgt_pkg::REG_POSITION_SCALE: scale_reg <= cfg_data[15:0];
                tptgt_pkg::REG_OFFSET_X:       off_x_reg <= cfg_data;
                tptgt_pkg::REG_OFFSET_Y:       off_y_reg <= cfg_data;
                tptgt_pkg::REG_OFFSET_Z:       off_z_reg <= cfg_data;
                default:                       ;   // unmapped index ignored
            endcase
        end
    end

    // stage valids and per-stage enables, a stage moves when it is empty
    // or its successor moves
    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] en;

    always_comb
    begin
        en[OSTG] = !valid_reg[OSTG] || out_ready;
        for (int i = OSTG - 1; i >= 0; i--)
            en[i] = !valid_reg[i] || en[i+1];
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[OSTG];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            if (en[0])
                valid_reg[0] <= in_valid;
            for (int i = 1; i < NSTG; i++)
                if (en[i])
                    valid_reg[i] <= valid_reg[i-1];
        end
    end

    // stage 1: rotate quaternion -90 deg about x (unscaled), remap position
    s1_t s1_next, s1_reg;
    always_comb
    begin
        s1_next.comp[0] = CW'(in_data.quat_w) + CW'(in_data.quat_x);
        s1_next.comp[1] = CW'(in_data.quat_x) - CW'(in_data.quat_w);
        s1_next.comp[2] = CW'(in_data.quat_y) + CW'(in_data.quat_z);
        s1_next.comp[3] = CW'(in_data.quat_z) - CW'(in_data.quat_y);
        s1_next.pm[0]   = PMW'(in_data.pos_x);
        s1_next.pm[1]   = -PMW'(in_data.pos_z);
        s1_next.pm[2]   = PMW'(in_data.pos_y);
    end
    always_ff @(posedge clk)
    begin
        if (en[0])
            s1_reg <= s1_next;
    end

    // stage 2: component products and position scaling
    s2_t s2_next, s2_reg;
    always_comb
    begin
        logic signed [CW-1:0] a, b, c, d;
        logic signed [16:0]   scl;
        a   = $signed(s1_reg.comp[0]);
        b   = $signed(s1_reg.comp[1]);
        c   = $signed(s1_reg.comp[2]);
        d   = $signed(s1_reg.comp[3]);
        scl = $signed({1'b0, scale_reg});
        s2_next.prod[0] = MW'(MW'(a) * MW'(a));
        s2_next.prod[1] = MW'(MW'(b) * MW'(b));
        s2_next.prod[2] = MW'(MW'(c) * MW'(c));
        s2_next.prod[3] = MW'(MW'(d) * MW'(d));
        s2_next.prod[4] = MW'(MW'(b) * MW'(c));
        s2_next.prod[5] = MW'(MW'(a) * MW'(d));
        s2_next.prod[6] = MW'(MW'(b) * MW'(d));
        s2_next.prod[7] = MW'(MW'(a) * MW'(c));
        s2_next.prod[8] = MW'(MW'(c) * MW'(d));
        s2_next.prod[9] = MW'(MW'(a) * MW'(b));
        for (int i = 0; i < 3; i++)
            s2_next.pp[i] = PRW'(PRW'($signed(s1_reg.pm[i])) * PRW'(scl));
    end
    always_ff @(posedge clk)
    begin
        if (en[1])
            s2_reg <= s2_next;
    end

    // stage 3: norm, matrix numerators, rounded position plus offset
    s3_t s3_next, s3_reg;
    always_comb
    begin
        logic signed [NW-1:0]  aa, bb, cc, dd, bc, ad, bd, ac, cd, ab, n;
        logic signed [PRW-1:0] sh;
        logic signed [31:0]    off [3];
        aa = NW'($signed(s2_reg.prod[0]));
        bb = NW'($signed(s2_reg.prod[1]));
        cc = NW'($signed(s2_reg.prod[2]));
        dd = NW'($signed(s2_reg.prod[3]));
        bc = NW'($signed(s2_reg.prod[4]));
        ad = NW'($signed(s2_reg.prod[5]));
        bd = NW'($signed(s2_reg.prod[6]));
        ac = NW'($signed(s2_reg.prod[7]));
        cd = NW'($signed(s2_reg.prod[8]));
        ab = NW'($signed(s2_reg.prod[9]));
        n  = aa + bb + cc + dd;
        s3_next.n      = n;
        s3_next.num[0] = n - ((cc + dd) <<< 1);
        s3_next.num[1] = (bc - ad) <<< 1;
        s3_next.num[2] = (bd + ac) <<< 1;
        s3_next.num[3] = (bc + ad) <<< 1;
        s3_next.num[4] = n - ((bb + dd) <<< 1);
        s3_next.num[5] = (cd - ab) <<< 1;
        s3_next.num[6] = (bd - ac) <<< 1;
        s3_next.num[7] = (cd + ab) <<< 1;
        s3_next.num[8] = n - ((bb + cc) <<< 1);
        off[0] = off_x_reg;
        off[1] = off_y_reg;
        off[2] = off_z_reg;
        for (int i = 0; i < 3; i++)
        begin
            // q.24 to q.16, half rounds toward plus infinity
            sh = ($signed(s2_reg.pp[i]) + PRW'(128)) >>> 8;
            s3_next.psum[i] = PSW'(sh) + PSW'(off[i]);
        end
    end
    always_ff @(posedge clk)
    begin
        if (en[2])
            s3_reg <= s3_next;
    end

    // divider entry: magnitudes, integer quotient bit, position saturation
    div_t div_reg [NSTEP+1];
    div_t div0_next;
    always_comb
    begin
        logic signed [NW-1:0]  nm;
        logic        [NW-1:0]  mag;
        logic        [DW-1:0]  r;
        logic signed [PSW-1:0] ps;
        div0_next.den  = s3_reg.n[DW-1:0];
        div0_next.zero = (s3_reg.n == '0);
        for (int l = 0; l < 9; l++)
        begin
            nm  = $signed(s3_reg.num[l]);
            mag = nm[NW-1] ? NW'(-nm) : NW'(nm);
            r   = mag[DW-1:0];
            div0_next.neg[l] = nm[NW-1];
            if (r >= div0_next.den)
            begin
                div0_next.r[l] = r - div0_next.den;
                div0_next.q[l] = QBW'(1);
            end
            else
            begin
                div0_next.r[l] = r;
                div0_next.q[l] = '0;
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            ps = $signed(s3_reg.psum[i]);
            if (ps > PSW'($signed({1'b0, {(PW-1){1'b1}}})))
                div0_next.game[i] = {1'b0, {(PW-1){1'b1}}};
            else if (ps < PSW'($signed({1'b1, {(PW-1){1'b0}}})))
                div0_next.game[i] = {1'b1, {(PW-1){1'b0}}};
            else
                div0_next.game[i] = ps[PW-1:0];
        end
    end
    always_ff @(posedge clk)
    begin
        if (en[DIV0])
            div_reg[0] <= div0_next;
    end

    // one restoring step per stage on all nine lanes
    function automatic div_t div_step(input div_t d);
        div_t          o;
        logic [DW-1:0] r2;
        o = d;
        for (int l = 0; l < 9; l++)
        begin
            r2 = {d.r[l][DW-2:0], 1'b0};
            if (r2 >= d.den)
            begin
                o.r[l] = r2 - d.den;
                o.q[l] = {d.q[l][QBW-2:0], 1'b1};
            end
            else
            begin
                o.r[l] = r2;
                o.q[l] = {d.q[l][QBW-2:0], 1'b0};
            end
        end
        return o;
    endfunction

    for (genvar k = 1; k <= NSTEP; k++)
    begin : g_div
        always_ff @(posedge clk)
        begin
            if (en[DIV0+k])
                div_reg[k] <= div_step(div_reg[k-1]);
        end
    end

    // output: round half away from zero, sign, identity for zero norm
    tptgt_pkg::pose_out_t out_next, out_reg;
    always_comb
    begin
        logic [QBW:0]              qr;
        logic [8:0][QW-1:0]        m;
        div_t                      d;
        d = div_reg[NSTEP];
        for (int l = 0; l < 9; l++)
        begin
            qr = (QBW+1)'(d.q[l]) + (QBW+1)'(1);
            qr = qr >> 1;
            if (d.zero)
                m[l] = (l % 4 == 0) ? QW'(1 << QF) : '0;
            else if (d.neg[l])
                m[l] = QW'(-qr[QW-1:0]);
            else
                m[l] = qr[QW-1:0];
        end
        out_next.game_x = d.game[0];
        out_next.game_y = d.game[1];
        out_next.game_z = d.game[2];
        out_next.m00 = m[0];
        out_next.m01 = m[1];
        out_next.m02 = m[2];
        out_next.m10 = m[3];
        out_next.m11 = m[4];
        out_next.m12 = m[5];
        out_next.m20 = m[6];
        out_next.m21 = m[7];
        out_next.m22 = m[8];
    end
    always_ff @(posedge clk)
    begin
        if (en[OSTG])
            out_reg <= out_next;
    end

    assign out_data = out_reg;

endmodule
`default_nettype wire
